### src/ggh_pkg.sv
package ggh_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_HEIGHT_BITS = 16;

  // stream item layout
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int HIN_W      = 16;
  localparam int ROW_LSB    = 0;
  localparam int COL_LSB    = ROW_LSB + ROW_W;
  localparam int HGT_LSB    = COL_LSB + COL_W;
  localparam int IN_DATA_W  = 32;
  localparam int RES_W      = 32;
  localparam int NUM_RES    = 5;
  localparam int OUT_DATA_W = RES_W * NUM_RES;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int MAP_W      = 7;

  localparam logic [2:0] REG_MAP_ROWS    = 3'd0;
  localparam logic [2:0] REG_MAP_COLS    = 3'd1;
  localparam logic [2:0] REG_GRAD_SCALE  = 3'd2;
  localparam logic [2:0] REG_CURV_SCALE  = 3'd3;
  localparam logic [2:0] REG_CROSS_SCALE = 3'd4;

  localparam logic [MAP_W-1:0]      RST_MAP_ROWS    = 7'd64;
  localparam logic [MAP_W-1:0]      RST_MAP_COLS    = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RST_GRAD_SCALE  = 32'd5461;
  localparam logic [CFG_DATA_W-1:0] RST_CURV_SCALE  = 32'd5461;
  localparam logic [CFG_DATA_W-1:0] RST_CROSS_SCALE = 32'd455;

  // stencil window
  localparam int         WIN_TAPS = 5;
  localparam int         WIN_HALF = 2;
  localparam logic [2:0] LAST_TAP = 3'd4;

  // result slots, also the order of the scaling passes
  localparam logic [2:0] RES_GX  = 3'd0;
  localparam logic [2:0] RES_GY  = 3'd1;
  localparam logic [2:0] RES_CXX = 3'd2;
  localparam logic [2:0] RES_CYY = 3'd3;
  localparam logic [2:0] RES_CXY = 3'd4;

  typedef struct packed {
    logic [MAP_W-1:0]      map_rows;
    logic [MAP_W-1:0]      map_cols;
    logic [CFG_DATA_W-1:0] grad_scale;
    logic [CFG_DATA_W-1:0] curv_scale;
    logic [CFG_DATA_W-1:0] cross_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_FINISH
  } state_t;

  // first derivative taps
  function automatic logic signed [7:0] w_d1(input logic [2:0] k);
    logic signed [7:0] w;
    case (k)
      3'd0:    w = -8'sd1;
      3'd1:    w = 8'sd8;
      3'd2:    w = 8'sd0;
      3'd3:    w = -8'sd8;
      3'd4:    w = 8'sd1;
      default: w = 8'sd0;
    endcase
    return w;
  endfunction

  // second derivative taps
  function automatic logic signed [7:0] w_d2(input logic [2:0] k);
    logic signed [7:0] w;
    case (k)
      3'd0:    w = -8'sd1;
      3'd1:    w = 8'sd16;
      3'd2:    w = -8'sd30;
      3'd3:    w = 8'sd16;
      3'd4:    w = -8'sd1;
      default: w = 8'sd0;
    endcase
    return w;
  endfunction

  // outer product of the first derivative taps, for the mixed term
  function automatic logic signed [7:0] w_cross(input logic [2:0] j, input logic [2:0] i);
    logic signed [15:0] p;
    p = 16'(w_d1(j)) * 16'(w_d1(i));
    return p[7:0];
  endfunction

endpackage

### src/ggh_regs.sv
module ggh_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ggh_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ggh_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ggh_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready,
  output ggh_pkg::cfg_t                      cfg
);
  import ggh_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_rows    <= RST_MAP_ROWS;
      cfg_r.map_cols    <= RST_MAP_COLS;
      cfg_r.grad_scale  <= RST_GRAD_SCALE;
      cfg_r.curv_scale  <= RST_CURV_SCALE;
      cfg_r.cross_scale <= RST_CROSS_SCALE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAP_ROWS:    cfg_r.map_rows    <= cfg_pwdata[MAP_W-1:0];
        REG_MAP_COLS:    cfg_r.map_cols    <= cfg_pwdata[MAP_W-1:0];
        REG_GRAD_SCALE:  cfg_r.grad_scale  <= cfg_pwdata;
        REG_CURV_SCALE:  cfg_r.curv_scale  <= cfg_pwdata;
        REG_CROSS_SCALE: cfg_r.cross_scale <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAP_ROWS:    cfg_prdata = CFG_DATA_W'(cfg_r.map_rows);
      REG_MAP_COLS:    cfg_prdata = CFG_DATA_W'(cfg_r.map_cols);
      REG_GRAD_SCALE:  cfg_prdata = cfg_r.grad_scale;
      REG_CURV_SCALE:  cfg_prdata = cfg_r.curv_scale;
      REG_CROSS_SCALE: cfg_prdata = cfg_r.cross_scale;
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

### src/ggh_grid.sv
module ggh_grid #(
  parameter int DEPTH = ggh_pkg::DEF_MAX_ROWS * ggh_pkg::DEF_MAX_COLS,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = ggh_pkg::DEF_HEIGHT_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### src/ggh_scale.sv
module ggh_scale #(
  parameter int SUM_W = ggh_pkg::DEF_HEIGHT_BITS + 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [SUM_W-1:0]        sum,
  input  logic [ggh_pkg::CFG_DATA_W-1:0] scale,
  output logic                           done,
  output logic [ggh_pkg::RES_W-1:0]      result
);
  import ggh_pkg::*;

  localparam int LO_W = (SUM_W + 1) / 2;
  localparam int HI_W = SUM_W - LO_W;
  localparam int PW   = SUM_W + CFG_DATA_W;
  localparam int QW   = PW - 16;
  localparam logic [PW-1:0]    ROUND_HALF = PW'(32768);
  localparam logic [RES_W-1:0] POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] NEG_MAG    = 32'h8000_0000;

  logic [SUM_W-1:0]           mag;
  logic                       v1_r, v2_r, v3_r;
  logic                       neg1_r, neg2_r, neg3_r;
  logic [LO_W-1:0]            lo1_r;
  logic [HI_W-1:0]            hi1_r, hi2_r;
  logic [CFG_DATA_W-1:0]      sc1_r, sc2_r;
  logic [LO_W+CFG_DATA_W-1:0] plo_r;
  logic [HI_W+CFG_DATA_W-1:0] phi;
  logic [PW-1:0]              full_r;
  logic [PW-1:0]              rnd;
  logic [QW-1:0]              q;
  logic [RES_W-1:0]           qs;

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign phi = (HI_W+CFG_DATA_W)'(hi2_r) * (HI_W+CFG_DATA_W)'(sc2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // magnitude split in halves, one partial product per stage
  always_ff @(posedge clk) begin
    neg1_r <= sum[SUM_W-1];
    lo1_r  <= mag[LO_W-1:0];
    hi1_r  <= mag[SUM_W-1:LO_W];
    sc1_r  <= scale;
    neg2_r <= neg1_r;
    hi2_r  <= hi1_r;
    sc2_r  <= sc1_r;
    plo_r  <= (LO_W+CFG_DATA_W)'(lo1_r) * (LO_W+CFG_DATA_W)'(sc1_r);
    neg3_r <= neg2_r;
    full_r <= PW'(plo_r) + (PW'(phi) << LO_W);
  end

  // round half away from zero on the magnitude, then saturate
  assign rnd = full_r + ROUND_HALF;
  assign q   = rnd[PW-1:16];

  always_comb begin
    if (!neg3_r) begin
      qs     = (q > QW'(POS_MAX)) ? POS_MAX : q[RES_W-1:0];
      result = qs;
    end else begin
      qs     = (q > QW'(NEG_MAG)) ? NEG_MAG : q[RES_W-1:0];
      result = -qs;
    end
  end

  assign done = v3_r;

endmodule

### src/grid_gradient_hessian_stencil_top.sv
// Height grid with gradient and Hessian queries over 5-tap finite differences.
// Input channel (in_*): an item with tuser kind 0 stores one height cell, kind 1
// queries the gradient and Hessian at a cell. Write items give no result item.
// Result channel (out_*): one item per query with five saturated 32-bit
// derivatives in tdata and the out-of-range flag in tuser.
// Configuration (cfg_*): APB-style registers map_rows, map_cols, grad_scale,
// curv_scale and cross_scale at byte addresses 0, 4, 8, 12, 16; write only
// while no item is in flight.
// Sequence: a write item is stored as it is accepted. A query reads its 5x5 window through
// the single grid read port, one cell per cycle, then runs the five sums through
// a three-stage scaling multiplier and loads the output register; only then is
// the next item taken. A query outside the map skips the window read and the
// scaling and goes straight to loading the output register.
// The result sits in an output register; a stalled receiver holds it there and
// the block keeps taking write items, while a later query waits to finish
// until the register frees.
// Reset restores the register defaults; grid cells hold nothing defined until
// written, and no query may touch an unwritten cell.
module grid_gradient_hessian_stencil_top #(
  parameter int MAX_ROWS    = ggh_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = ggh_pkg::DEF_MAX_COLS,
  parameter int HEIGHT_BITS = ggh_pkg::DEF_HEIGHT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ggh_pkg::IN_DATA_W-1:0]   in_tdata,   // row, col, height, zero pad
  input  logic [0:0]                      in_tuser,   // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ggh_pkg::OUT_DATA_W-1:0]  out_tdata,  // grad_x, grad_y, curv_xx, curv_yy, curv_xy
  output logic [0:0]                      out_tuser,  // out_of_range
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ggh_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ggh_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ggh_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import ggh_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RSW   = $clog2(MAX_ROWS + 1);
  localparam int CSW   = $clog2(MAX_COLS + 1);
  localparam int NW_A  = (RSW > CSW) ? RSW : CSW;
  localparam int NW    = (NW_A > MAP_W) ? NW_A : MAP_W;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = HEIGHT_BITS + 9;

  function automatic logic [NW-1:0] clamp_dim(input logic [NW-1:0] v,
                                              input logic [NW-1:0] maxv);
    logic [NW-1:0] r;
    if (v < NW'(WIN_TAPS))  r = NW'(WIN_TAPS);
    else if (v > maxv)      r = maxv;
    else                    r = v;
    return r;
  endfunction

  function automatic logic [NW-1:0] win_start(input logic [NW-1:0] idx,
                                              input logic [NW-1:0] size);
    logic [NW-1:0] s;
    logic [NW-1:0] lim;
    s   = (idx >= NW'(WIN_HALF)) ? idx - NW'(WIN_HALF) : '0;
    lim = size - NW'(WIN_TAPS);
    return (s > lim) ? lim : s;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  cfg_t cfg;

  ggh_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // input item fields
  logic                     in_kind;
  logic [ROW_W-1:0]         in_row;
  logic [COL_W-1:0]         in_col;
  logic signed [HIN_W-1:0]  in_height;
  logic                     in_acc;

  assign in_kind   = in_tuser[0];
  assign in_row    = in_tdata[ROW_LSB +: ROW_W];
  assign in_col    = in_tdata[COL_LSB +: COL_W];
  assign in_height = in_tdata[HGT_LSB +: HIN_W];
  assign in_acc    = in_tvalid & in_tready;

  // map geometry for the incoming query
  logic [NW-1:0] row_w, col_w, rows_eff, cols_eff, wr0_c, wc0_c, rdiff, cdiff;
  logic          oor_c;

  assign row_w    = NW'(in_row);
  assign col_w    = NW'(in_col);
  assign rows_eff = clamp_dim(NW'(cfg.map_rows), NW'(MAX_ROWS));
  assign cols_eff = clamp_dim(NW'(cfg.map_cols), NW'(MAX_COLS));
  assign oor_c    = (row_w >= rows_eff) | (col_w >= cols_eff);
  assign wr0_c    = win_start(row_w, rows_eff);
  assign wc0_c    = win_start(col_w, cols_eff);
  assign rdiff    = row_w - wr0_c;
  assign cdiff    = col_w - wc0_c;

  state_t state_r, state_nxt;

  logic [NW-1:0]  wr0_r, wc0_r;
  logic [2:0]     rj_r, ci_r;
  logic           oor_r;
  logic [2:0]     i_r, j_r, di_r, dj_r, k_r, kd_r;
  logic           rd_v_r;

  // grid memory
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [HEIGHT_BITS-1:0] mem_wdata, mem_rdata;
  logic [NW-1:0]          rd_row, rd_col;

  assign mem_we    = in_acc & (in_kind == KIND_WRITE) &
                     (row_w < NW'(MAX_ROWS)) & (col_w < NW'(MAX_COLS));
  assign mem_waddr = cell_addr(row_w[RW-1:0], col_w[CW-1:0]);
  assign mem_wdata = HEIGHT_BITS'(in_height);
  assign rd_row    = wr0_r + NW'(j_r);
  assign rd_col    = wc0_r + NW'(i_r);
  assign mem_raddr = cell_addr(rd_row[RW-1:0], rd_col[CW-1:0]);

  ggh_grid #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (HEIGHT_BITS)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // window accumulation, one cell per cycle
  logic signed [SUM_W-1:0] acc_r [NUM_RES];
  logic signed [SUM_W-1:0] hx, t_xy, t_gx, t_cxx, t_gy, t_cyy;

  assign hx    = SUM_W'($signed(mem_rdata));
  assign t_xy  = hx * SUM_W'(w_cross(dj_r, di_r));
  assign t_gx  = hx * SUM_W'(w_d1(dj_r));
  assign t_cxx = hx * SUM_W'(w_d2(dj_r));
  assign t_gy  = hx * SUM_W'(w_d1(di_r));
  assign t_cyy = hx * SUM_W'(w_d2(di_r));

  // scaling unit, fed one sum per cycle
  logic                    sc_start, sc_done;
  logic [CFG_DATA_W-1:0]   sc_scale;
  logic [RES_W-1:0]        sc_result;
  logic [RES_W-1:0]        res_r [NUM_RES];

  always_comb begin
    case (k_r)
      RES_GX, RES_GY:   sc_scale = cfg.grad_scale;
      RES_CXX, RES_CYY: sc_scale = cfg.curv_scale;
      default:          sc_scale = cfg.cross_scale;
    endcase
  end

  ggh_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sc_start),
    .sum    (acc_r[k_r]),
    .scale  (sc_scale),
    .done   (sc_done),
    .result (sc_result)
  );

  // output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;
  logic                  out_free, out_load;

  assign out_free   = ~out_tvalid_r | out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_kind == KIND_QUERY) begin
          state_nxt = oor_c ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        if (i_r == LAST_TAP && j_r == LAST_TAP) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (k_r == RES_CXY) begin
          state_nxt = ST_SCALE_WAIT;
        end
      end
      ST_SCALE_WAIT: begin
        if (sc_done && kd_r == RES_CXY) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    mem_re    = 1'b0;
    sc_start  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_READ:   mem_re    = 1'b1;
      ST_SCALE:  sc_start  = 1'b1;
      ST_FINISH: out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      kd_r         <= '0;
      rd_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= mem_re;
      if (in_acc && in_kind == KIND_QUERY) begin
        i_r  <= '0;
        j_r  <= '0;
        k_r  <= '0;
        kd_r <= '0;
      end
      if (mem_re) begin
        if (j_r == LAST_TAP) begin
          j_r <= '0;
          i_r <= i_r + 3'd1;
        end else begin
          j_r <= j_r + 3'd1;
        end
      end
      if (sc_start) begin
        k_r <= k_r + 3'd1;
      end
      if (sc_done) begin
        kd_r <= kd_r + 3'd1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    di_r <= i_r;
    dj_r <= j_r;
    if (in_acc && in_kind == KIND_QUERY) begin
      wr0_r <= wr0_c;
      wc0_r <= wc0_c;
      rj_r  <= rdiff[2:0];
      ci_r  <= cdiff[2:0];
      oor_r <= oor_c;
      for (int n = 0; n < NUM_RES; n++) begin
        acc_r[n] <= '0;
      end
    end else if (rd_v_r) begin
      acc_r[RES_CXY] <= acc_r[RES_CXY] + t_xy;
      // queried column of the window feeds the row-direction terms
      if (di_r == ci_r) begin
        acc_r[RES_GX]  <= acc_r[RES_GX] + t_gx;
        acc_r[RES_CXX] <= acc_r[RES_CXX] + t_cxx;
      end
      // queried row feeds the column-direction terms
      if (dj_r == rj_r) begin
        acc_r[RES_GY]  <= acc_r[RES_GY] + t_gy;
        acc_r[RES_CYY] <= acc_r[RES_CYY] + t_cyy;
      end
    end
    if (sc_done) begin
      res_r[kd_r] <= sc_result;
    end
    if (out_load) begin
      out_tuser_r <= oor_r;
      if (oor_r) begin
        out_tdata_r <= '0;
      end else begin
        out_tdata_r <= {res_r[RES_CXY], res_r[RES_CYY], res_r[RES_CXX],
                        res_r[RES_GY], res_r[RES_GX]};
      end
    end
  end

endmodule
